// ===== src/prts_pkg.sv =====
`timescale 1ns / 1ps

package prts_pkg;

	localparam int TASK_SLOTS_DEF  = 16;
	localparam int PRIO_LEVELS_DEF = 16;

	localparam int MODE_W  = 2;
	localparam int INDEX_W = 4;
	localparam int STATE_W = 3;
	localparam int PRIO_W  = 4;
	localparam int SLEEP_W = 32;

	// item modes
	localparam logic [MODE_W-1:0] MODE_SCHED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	// task states
	localparam logic [STATE_W-1:0] ST_INVALID = 3'd0;
	localparam logic [STATE_W-1:0] ST_READY   = 3'd1;
	localparam logic [STATE_W-1:0] ST_DELAYED = 3'd2;
	localparam logic [STATE_W-1:0] ST_BLOCKED = 3'd3;
	localparam logic [STATE_W-1:0] ST_STOPPED = 3'd4;

	// register file
	localparam int                  CFG_ADDR_W     = 3;
	localparam int                  CFG_DATA_W     = 32;
	localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_PMODE = 3'd0;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [INDEX_W-1:0] task_index;
		logic [STATE_W-1:0] task_state;
		logic [PRIO_W-1:0]  task_priority;
		logic [SLEEP_W-1:0] sleep_ticks;
	} sched_cmd_t;

	typedef struct packed {
		logic [INDEX_W-1:0] chosen_task;
		logic               found;
	} sched_result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BEST,
		S_PICK,
		S_SEARCH,
		S_TICK
	} sched_state_t;

	typedef enum logic [1:0] {
		OP_BEST,
		OP_MATCH_LVL,
		OP_MATCH_ANY,
		OP_TICK
	} scan_op_t;

	typedef struct packed {
		scan_op_t          op;
		logic              any;
		logic [PRIO_W-1:0] best;
	} scan_ctl_t;

	typedef struct packed {
		logic               take_best;
		logic               hit;
		logic               wake;
		logic               dec;
		logic [SLEEP_W-1:0] sleep_next;
	} scan_res_t;

endpackage

// ===== src/prts_entry_store.sv =====
`timescale 1ns / 1ps

module prts_entry_store #(
	parameter int TASK_SLOTS = prts_pkg::TASK_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(TASK_SLOTS)-1:0] rd_addr,
	output logic [prts_pkg::STATE_W-1:0]  rd_state_s1,
	output logic [prts_pkg::PRIO_W-1:0]   rd_prio_s1,
	output logic [prts_pkg::SLEEP_W-1:0]  rd_sleep_s1,
	input  logic                          st_we,
	input  logic [$clog2(TASK_SLOTS)-1:0] st_waddr,
	input  logic [prts_pkg::STATE_W-1:0]  st_wdata,
	input  logic                          mem_we,
	input  logic [$clog2(TASK_SLOTS)-1:0] mem_waddr,
	input  logic [prts_pkg::PRIO_W-1:0]   mem_wprio,
	input  logic [prts_pkg::SLEEP_W-1:0]  mem_wsleep
);
	import prts_pkg::*;

	localparam int MEM_W = PRIO_W + SLEEP_W;

	logic [STATE_W-1:0] state_q [TASK_SLOTS];
	logic [MEM_W-1:0]   mem_q   [TASK_SLOTS];
	logic [MEM_W-1:0]   mem_rd_s1;

	// task states reset to invalid, priority and sleep live in plain memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				state_q[i] <= ST_INVALID;
			end
			rd_state_s1 <= ST_INVALID;
		end else begin
			if (st_we) begin
				state_q[st_waddr] <= st_wdata;
			end
			rd_state_s1 <= state_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= {mem_wprio, mem_wsleep};
		end
		mem_rd_s1 <= mem_q[rd_addr];
	end

	assign rd_prio_s1  = mem_rd_s1[MEM_W-1:SLEEP_W];
	assign rd_sleep_s1 = mem_rd_s1[SLEEP_W-1:0];

endmodule

// ===== src/prts_scan_unit.sv =====
`timescale 1ns / 1ps

module prts_scan_unit (
	input  prts_pkg::scan_ctl_t           ctl,
	input  logic [prts_pkg::STATE_W-1:0]  entry_state,
	input  logic [prts_pkg::PRIO_W-1:0]   entry_prio,
	input  logic [prts_pkg::SLEEP_W-1:0]  entry_sleep,
	output prts_pkg::scan_res_t           res
);
	import prts_pkg::*;

	logic ready;
	logic delayed;

	assign ready   = (entry_state == ST_READY);
	assign delayed = (entry_state == ST_DELAYED);

	always_comb begin
		res            = '0;
		res.sleep_next = entry_sleep - SLEEP_W'(1);
		unique case (ctl.op)
			OP_BEST: begin
				res.take_best = ready && (!ctl.any || (entry_prio < ctl.best));
			end
			OP_MATCH_LVL: begin
				res.hit = ready && (entry_prio == ctl.best);
			end
			OP_MATCH_ANY: begin
				res.hit = ready;
			end
			OP_TICK: begin
				res.wake = delayed && (entry_sleep == '0);
				res.dec  = delayed && (entry_sleep != '0);
			end
		endcase
	end

endmodule

// ===== src/priority_round_robin_task_scheduler_unit.sv =====
// channel  | handshake               | payload            | notes
// ---------+-------------------------+--------------------+------------------------------
// command  | start in, busy out      | cmd   (sched_cmd_t)| taken when start && !busy
// result   | done out                | result (sched_result_t) | one word per command, 1 cycle
// config   | psel/penable/pwrite/... | pwdata, prdata     | priority_mode at byte addr 0
//
// write and unused-mode commands: result word in the cycle after the command
// tick: one table entry read and updated per cycle
// schedule, plain mode: the search stops at the first hit or after the last slot
// schedule, priority mode: a pass over the whole table finds the best ready priority,
//   then, if any task is ready, a search of that level stops at the first hit;
//   the task table has a single read port and is read one entry a cycle
// reset invalidates all tasks, zeroes the level pointers, parks the plain pointer on
//   the last slot and sets priority_mode; the result receiver cannot stall
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler_unit #(
	parameter int TASK_SLOTS      = prts_pkg::TASK_SLOTS_DEF,
	parameter int PRIORITY_LEVELS = prts_pkg::PRIO_LEVELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  prts_pkg::sched_cmd_t              cmd,
	output logic                              done,
	output prts_pkg::sched_result_t           result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [prts_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [prts_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [prts_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import prts_pkg::*;

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
	localparam int LVL_W  = $clog2(PRIORITY_LEVELS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
	localparam logic [PRIO_W-1:0] LAST_PRIO = PRIO_W'(PRIORITY_LEVELS - 1);

	// sequencer state
	sched_state_t      fsm_q, fsm_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] addr_q;
	logic              use_prio_q;
	logic              any_q;
	logic [PRIO_W-1:0] best_q;

	// scan pipeline, one entry in flight behind the table read
	logic              valid_s1;
	logic              last_s1;
	logic [SLOT_W-1:0] idx_s1;

	// round-robin pointers
	logic [SLOT_W-1:0] level_ptr_q [PRIORITY_LEVELS];
	logic [SLOT_W-1:0] plain_ptr_q;
	logic [SLOT_W-1:0] level_ptr_rd;

	logic          prio_mode_q;
	logic          done_q;
	sched_result_t result_q;

	// table read data
	logic [STATE_W-1:0] rd_state_s1;
	logic [PRIO_W-1:0]  rd_prio_s1;
	logic [SLEEP_W-1:0] rd_sleep_s1;

	// control decoded from the state
	scan_ctl_t ctl;
	scan_res_t res;
	logic      accept;
	logic      issue;
	logic      finish;
	logic      hit_take;
	logic      scan_end;

	// command write decode
	logic               wr_cmd;
	logic               wr_in_range;
	logic [STATE_W-1:0] wr_state;
	logic [PRIO_W-1:0]  wr_prio;

	// table write ports
	logic               st_we;
	logic [SLOT_W-1:0]  st_waddr;
	logic [STATE_W-1:0] st_wdata;
	logic               mem_we;
	logic [SLOT_W-1:0]  mem_waddr;
	logic [PRIO_W-1:0]  mem_wprio;
	logic [SLEEP_W-1:0] mem_wsleep;

	logic cfg_wr;
	logic pmode_sel;

	assign busy   = (fsm_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	// registers sit on word addresses, the low two byte bits are ignored
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pmode_sel = (paddr[CFG_ADDR_W-1:2] == CFG_ADDR_PMODE[CFG_ADDR_W-1:2]);
	assign prdata    = pmode_sel ? {{(CFG_DATA_W-1){1'b0}}, prio_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_mode_q <= 1'b1;
		end else if (cfg_wr && pmode_sel) begin
			prio_mode_q <= pwdata[0];
		end
	end

	// ------------------------------------------------------------------
	// write command: clamp state and priority, drop out-of-range slots
	// ------------------------------------------------------------------
	assign wr_cmd      = accept && (cmd.mode == MODE_WRITE);
	assign wr_in_range = (32'(cmd.task_index) < TASK_SLOTS);
	assign wr_state    = (cmd.task_state > ST_STOPPED) ? ST_STOPPED : cmd.task_state;
	assign wr_prio     = (32'(cmd.task_priority) >= PRIORITY_LEVELS) ? LAST_PRIO
	                                                                  : cmd.task_priority;

	// ------------------------------------------------------------------
	// task table and the shared compare/decrement unit
	// ------------------------------------------------------------------
	prts_entry_store #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_addr     (addr_q),
		.rd_state_s1 (rd_state_s1),
		.rd_prio_s1  (rd_prio_s1),
		.rd_sleep_s1 (rd_sleep_s1),
		.st_we       (st_we),
		.st_waddr    (st_waddr),
		.st_wdata    (st_wdata),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wprio   (mem_wprio),
		.mem_wsleep  (mem_wsleep)
	);

	prts_scan_unit u_scan (
		.ctl         (ctl),
		.entry_state (rd_state_s1),
		.entry_prio  (rd_prio_s1),
		.entry_sleep (rd_sleep_s1),
		.res         (res)
	);

	// a write command writes its slot; a tick writes back the entry that just came out of the table
	always_comb begin
		st_we      = 1'b0;
		st_waddr   = idx_s1;
		st_wdata   = ST_READY;
		mem_we     = 1'b0;
		mem_waddr  = idx_s1;
		mem_wprio  = rd_prio_s1;
		mem_wsleep = res.sleep_next;
		if (wr_cmd) begin
			st_we      = wr_in_range;
			st_waddr   = SLOT_W'(cmd.task_index);
			st_wdata   = wr_state;
			mem_we     = wr_in_range;
			mem_waddr  = SLOT_W'(cmd.task_index);
			mem_wprio  = wr_prio;
			mem_wsleep = cmd.sleep_ticks;
		end else if (fsm_q == S_TICK && valid_s1) begin
			st_we  = res.wake;
			mem_we = res.dec;
		end
	end

	// ------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------
	assign scan_end = valid_s1 && last_s1;

	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			S_IDLE: begin
				if (accept && cmd.mode == MODE_SCHED) begin
					fsm_d = prio_mode_q ? S_BEST : S_SEARCH;
				end else if (accept && cmd.mode == MODE_TICK) begin
					fsm_d = S_TICK;
				end
			end
			S_BEST: begin
				if (scan_end) begin
					fsm_d = S_PICK;
				end
			end
			S_PICK: begin
				fsm_d = any_q ? S_SEARCH : S_IDLE;
			end
			S_SEARCH: begin
				if (valid_s1 && (res.hit || last_s1)) begin
					fsm_d = S_IDLE;
				end
			end
			S_TICK: begin
				if (scan_end) begin
					fsm_d = S_IDLE;
				end
			end
			default: begin
				fsm_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		ctl.any  = any_q;
		ctl.best = best_q;
		ctl.op   = OP_BEST;
		issue    = 1'b0;
		finish   = 1'b0;
		hit_take = 1'b0;
		unique case (fsm_q)
			S_IDLE: begin
			end
			S_BEST: begin
				issue = (cnt_q < CNT_W'(TASK_SLOTS));
			end
			S_PICK: begin
				finish = !any_q;
			end
			S_SEARCH: begin
				ctl.op   = use_prio_q ? OP_MATCH_LVL : OP_MATCH_ANY;
				issue    = (cnt_q < CNT_W'(TASK_SLOTS));
				hit_take = valid_s1 && res.hit;
				finish   = valid_s1 && (res.hit || last_s1);
			end
			S_TICK: begin
				ctl.op = OP_TICK;
				issue  = (cnt_q < CNT_W'(TASK_SLOTS));
				finish = scan_end;
			end
			default: begin
			end
		endcase
	end

	assign level_ptr_rd = level_ptr_q[LVL_W'(best_q)];

	// ------------------------------------------------------------------
	// sequencer registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= S_IDLE;
			cnt_q      <= '0;
			addr_q     <= '0;
			use_prio_q <= 1'b0;
			any_q      <= 1'b0;
			best_q     <= '0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			idx_s1     <= '0;
		end else begin
			fsm_q    <= fsm_d;
			valid_s1 <= issue;
			last_s1  <= (cnt_q == CNT_W'(TASK_SLOTS - 1));
			idx_s1   <= addr_q;

			priority if (accept) begin
				cnt_q      <= '0;
				any_q      <= 1'b0;
				use_prio_q <= prio_mode_q;
				// plain search starts just past the plain pointer
				if (cmd.mode == MODE_SCHED && !prio_mode_q) begin
					addr_q <= (plain_ptr_q == LAST_SLOT) ? '0 : plain_ptr_q + SLOT_W'(1);
				end else begin
					addr_q <= '0;
				end
			end else if (fsm_q == S_PICK) begin
				// level search starts just past that level's pointer
				cnt_q  <= '0;
				addr_q <= (level_ptr_rd == LAST_SLOT) ? '0 : level_ptr_rd + SLOT_W'(1);
			end else if (issue) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				addr_q <= (addr_q == LAST_SLOT) ? '0 : addr_q + SLOT_W'(1);
			end

			// best priority among ready entries
			if (fsm_q == S_BEST && valid_s1 && res.take_best) begin
				best_q <= rd_prio_s1;
				any_q  <= 1'b1;
			end
		end
	end

	// pointer moves to the chosen entry; nothing moves on a miss
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRIORITY_LEVELS; i++) begin
				level_ptr_q[i] <= '0;
			end
			plain_ptr_q <= LAST_SLOT;
		end else if (hit_take) begin
			if (use_prio_q) begin
				level_ptr_q[LVL_W'(best_q)] <= idx_s1;
			end else begin
				plain_ptr_q <= idx_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// result word, one cycle strobe
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= finish || (accept && (cmd.mode == MODE_WRITE || cmd.mode == MODE_NONE));
			if (hit_take) begin
				result_q.chosen_task <= INDEX_W'(idx_s1);
				result_q.found       <= 1'b1;
			end else begin
				result_q <= '0;
			end
		end
	end

endmodule

// ===== src/prts_checker.sv =====
`timescale 1ns / 1ps

module prts_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input prts_pkg::sched_cmd_t    cmd,
	input logic                    done,
	input prts_pkg::sched_result_t result
);
	import prts_pkg::*;

	// write and unused-mode commands answer next cycle with an empty word
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.mode == MODE_WRITE || cmd.mode == MODE_NONE)
		|=> done && !result.found && result.chosen_task == '0)
		else $error("short command did not answer with an empty word");

	// a long command ends with its result word
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result word");

	// busy only starts on a taken command
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// a miss never names a task
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.chosen_task == '0)
		else $error("miss carries a task index");

endmodule

bind priority_round_robin_task_scheduler_unit prts_checker u_prts_checker (.*);

// ===== tb/sv/priority_round_robin_task_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler_unit_tb;
	import prts_pkg::*;

	localparam int SLOTS = TASK_SLOTS_DEF;
	// limits with a wide margin over the busy time of the longest command
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
	// register slot past the only real one, used to check that writes there do nothing
	localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE = 3'd4;

	logic                  clk;
	logic                  arst_n  = 1'b0;
	logic                  start   = 1'b0;
	logic                  busy;
	sched_cmd_t            cmd     = '0;
	logic                  done;
	sched_result_t         result;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// mirror of the task table, the round-robin pointers and the mode register
	logic [STATE_W-1:0] tbl_state [SLOTS];
	logic [PRIO_W-1:0]  tbl_prio  [SLOTS];
	logic [SLEEP_W-1:0] tbl_sleep [SLOTS];
	logic [INDEX_W-1:0] lvl_ptr   [PRIO_LEVELS_DEF];
	logic [INDEX_W-1:0] rr_ptr;
	logic               prio_mode;

	// result words still owed by the block, oldest first
	sched_result_t pending_words [$];

	int errors       = 0;
	int stall_cycles = 0;
	int n_sched      = 0;
	int n_found      = 0;
	int n_tick       = 0;
	int n_write      = 0;
	int n_unused     = 0;
	int n_cfg        = 0;

	priority_round_robin_task_scheduler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// applies one accepted command to the mirror and returns the word it owes
	function automatic sched_result_t schedule_result(input sched_cmd_t c);
		sched_result_t      r;
		logic               any_ready;
		logic [PRIO_W-1:0]  best;
		logic [INDEX_W-1:0] base;
		logic [INDEX_W-1:0] idx;
		logic [STATE_W-1:0] st;
		r = '0;
		case (c.mode)
			MODE_SCHED: begin
				// best (lowest) priority among ready entries
				any_ready = 1'b0;
				best      = '0;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_state[i] == ST_READY && (!any_ready || tbl_prio[i] < best)) begin
						best      = tbl_prio[i];
						any_ready = 1'b1;
					end
				end
				// scan starts one past the pointer and ends on the pointer itself
				base = prio_mode ? lvl_ptr[best] : rr_ptr;
				if (any_ready) begin
					for (int k = 1; k <= SLOTS; k++) begin
						idx = base + k[INDEX_W-1:0];
						if (!r.found && tbl_state[idx] == ST_READY &&
								(!prio_mode || tbl_prio[idx] == best)) begin
							r.found       = 1'b1;
							r.chosen_task = idx;
						end
					end
				end
				// pointers move only on a hit
				if (r.found) begin
					if (prio_mode)
						lvl_ptr[best] = r.chosen_task;
					else
						rr_ptr = r.chosen_task;
				end
			end
			MODE_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_state[i] == ST_DELAYED) begin
						if (tbl_sleep[i] == '0)
							tbl_state[i] = ST_READY;
						else
							tbl_sleep[i] = tbl_sleep[i] - 1'b1;
					end
				end
			end
			MODE_WRITE: begin
				// out-of-range state codes collapse to stopped
				st = (c.task_state > ST_STOPPED) ? ST_STOPPED : c.task_state;
				tbl_state[c.task_index] = st;
				tbl_prio[c.task_index]  = c.task_priority;
				tbl_sleep[c.task_index] = c.sleep_ticks;
			end
			default: begin
				// unused mode: no change, all-zero word
			end
		endcase
		return r;
	endfunction

	// one command word: hold start until the block takes it, then log what it owes
	task automatic send_word(input sched_cmd_t c);
		sched_result_t r;
		cmd   <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		r = schedule_result(c);
		pending_words.push_back(r);
		case (c.mode)
			MODE_SCHED: begin
				n_sched++;
				if (r.found)
					n_found++;
			end
			MODE_TICK:  n_tick++;
			MODE_WRITE: n_write++;
			default:    n_unused++;
		endcase
	endtask

	// non-write command; the unused fields carry noise
	task automatic send_mode(input logic [MODE_W-1:0] m);
		sched_cmd_t c;
		c.mode          = m;
		c.task_index    = INDEX_W'($urandom);
		c.task_state    = STATE_W'($urandom);
		c.task_priority = PRIO_W'($urandom);
		c.sleep_ticks   = $urandom;
		send_word(c);
	endtask

	task automatic send_write(input logic [INDEX_W-1:0] idx, input logic [STATE_W-1:0] st,
			input logic [PRIO_W-1:0] pr, input logic [SLEEP_W-1:0] slp);
		sched_cmd_t c;
		c.mode          = MODE_WRITE;
		c.task_index    = idx;
		c.task_state    = st;
		c.task_priority = pr;
		c.sleep_ticks   = slp;
		send_word(c);
	endtask

	// drop start for a short random burst
	task automatic pause();
		start <= 1'b0;
		repeat ($urandom_range(1, 4)) @(posedge clk);
	endtask

	// every word has a result, so idle means nothing owed and busy low
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0 || busy);
	endtask

	// apb write, then read back the mode register through the same select
	task automatic set_register(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		logic [CFG_DATA_W-1:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands at this edge
		if (addr == CFG_ADDR_PMODE)
			prio_mode = data[0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= CFG_ADDR_PMODE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = {{(CFG_DATA_W-1){1'b0}}, prio_mode};
		if (prdata !== want) begin
			$display("%0t: priority_mode read back, expected %0h actual %0h", $time, want, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		// the bus goes idle before the next transfer
		@(posedge clk);
		n_cfg++;
	endtask

	// random word shaped to keep the table busy: mostly writes and ticks,
	// small priorities for ties, short sleeps so delayed tasks wake
	function automatic sched_cmd_t random_command();
		sched_cmd_t c;
		int         r;
		int         s;
		c.mode          = MODE_SCHED;
		c.task_index    = INDEX_W'($urandom);
		c.task_state    = STATE_W'($urandom);
		c.task_priority = PRIO_W'($urandom);
		c.sleep_ticks   = $urandom;
		r = $urandom_range(0, 99);
		if (r < 30)
			c.mode = MODE_SCHED;
		else if (r < 52)
			c.mode = MODE_TICK;
		else if (r < 97) begin
			c.mode = MODE_WRITE;
			s = $urandom_range(0, 99);
			if (s < 38)
				c.task_state = ST_READY;
			else if (s < 62)
				c.task_state = ST_DELAYED;
			else if (s < 74)
				c.task_state = ST_INVALID;
			else if (s < 82)
				c.task_state = ST_BLOCKED;
			else if (s < 90)
				c.task_state = ST_STOPPED;
			else
				c.task_state = STATE_W'($urandom_range(5, 7));
			if ($urandom_range(0, 4) != 0)
				c.task_priority = PRIO_W'($urandom_range(0, 3));
			if (c.task_state == ST_DELAYED && $urandom_range(0, 9) < 7)
				c.sleep_ticks = $urandom_range(0, 4);
		end else
			c.mode = MODE_NONE;
		return c;
	endfunction

	task automatic run_random(input int count, input bit idle_on, input int toggle_every);
		for (int i = 0; i < count; i++) begin
			// flip the scheduling mode between phases, sometimes poke the spare slot too
			if (toggle_every != 0 && i != 0 && i % toggle_every == 0) begin
				settle();
				if ($urandom_range(0, 3) == 0)
					set_register(CFG_ADDR_SPARE, $urandom);
				set_register(CFG_ADDR_PMODE, {{(CFG_DATA_W-1){1'b0}}, ~prio_mode});
			end
			// now and then empty the whole table so the no-ready path shows up
			if ($urandom_range(0, 149) == 0) begin
				for (int s = 0; s < SLOTS; s++)
					send_write(s[INDEX_W-1:0], ST_INVALID, PRIO_W'($urandom), $urandom);
			end
			if (idle_on && $urandom_range(0, 99) < 30)
				pause();
			send_word(random_command());
		end
	endtask

	// nothing ready after reset, unused mode, tick on an empty table
	task automatic test_empty_table();
		send_mode(MODE_SCHED);
		send_mode(MODE_NONE);
		send_mode(MODE_TICK);
	endtask

	// index, priority, state and sleep extremes; round robin within one level
	task automatic test_write_extremes();
		send_write(4'd0, ST_READY, 4'd15, 32'h0000_0000);
		send_write(4'd15, ST_READY, 4'd15, 32'hFFFF_FFFF);
		send_mode(MODE_SCHED);
		send_mode(MODE_SCHED);
		send_write(4'd7, 3'd7, 4'd0, 32'h0000_0000);
		send_write(4'd8, 3'd5, 4'd0, 32'hFFFF_FFFF);
		send_write(4'd9, ST_BLOCKED, 4'd0, 32'h0000_0000);
		send_write(4'd10, 3'd6, 4'd0, 32'h0000_0000);
		send_mode(MODE_SCHED);
	endtask

	// delayed tasks wake on the tick after their count reaches zero
	task automatic test_tick_wakeup();
		send_write(4'd3, ST_DELAYED, 4'd0, 32'd0);
		send_write(4'd4, ST_DELAYED, 4'd0, 32'd1);
		send_mode(MODE_TICK);
		send_mode(MODE_SCHED);
		send_mode(MODE_TICK);
		send_mode(MODE_SCHED);
	endtask

	// write to an unused register slot, then both scheduling modes
	task automatic test_register_port();
		settle();
		set_register(CFG_ADDR_SPARE, '0);
		send_mode(MODE_SCHED);
		settle();
		set_register(CFG_ADDR_PMODE, '0);
		send_mode(MODE_SCHED);
		send_mode(MODE_SCHED);
		settle();
		set_register(CFG_ADDR_PMODE, 32'd1);
		send_mode(MODE_SCHED);
		send_write(4'd3, ST_INVALID, 4'd0, 32'd0);
	endtask

	task automatic test_random_priority();
		settle();
		set_register(CFG_ADDR_PMODE, 32'd1);
		run_random(550, 1'b1, 0);
	endtask

	task automatic test_random_plain();
		settle();
		set_register(CFG_ADDR_PMODE, '0);
		run_random(400, 1'b1, 0);
	endtask

	task automatic test_mode_switching();
		run_random(350, 1'b1, 50);
	endtask

	// last stretch: start never drops between words
	task automatic test_back_to_back();
		settle();
		set_register(CFG_ADDR_PMODE, 32'hFFFF_FFFF);
		run_random(200, 1'b0, 0);
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_words.size() == 0) begin
					$display("%0t: result word with none owed, expected none actual %0d/%0d",
						$time, result.chosen_task, result.found);
					errors++;
				end else begin
					want = pending_words.pop_front();
					if (result.chosen_task !== want.chosen_task) begin
						$display("%0t: chosen_task mismatch, expected %0d actual %0d",
							$time, want.chosen_task, result.chosen_task);
						errors++;
					end
					if (result.found !== want.found) begin
						$display("%0t: found mismatch, expected %0d actual %0d",
							$time, want.found, result.found);
						errors++;
					end
				end
			end
			// any accepted word on either side restarts the count
			if (done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		// mirror of the reset state
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = ST_INVALID;
			tbl_prio[i]  = '0;
			tbl_sleep[i] = '0;
		end
		for (int i = 0; i < PRIO_LEVELS_DEF; i++)
			lvl_ptr[i] = '0;
		rr_ptr    = INDEX_W'(SLOTS - 1);
		prio_mode = 1'b1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_write_extremes();
		test_tick_wakeup();
		test_register_port();
		test_random_priority();
		test_random_plain();
		test_mode_switching();
		test_back_to_back();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words: %0d schedule (%0d found a task), %0d tick, %0d write, %0d unused",
			n_sched + n_tick + n_write + n_unused, n_sched, n_found, n_tick, n_write, n_unused);
		$display("register port: %0d writes with read-back, both scheduling modes", n_cfg);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
